// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an antecedent always brings its consequent in the same cycle.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Check that a condition never holds.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/sdta_pkg.sv
// Types and constants of the signed decimal to ASCII converter.
package sdta_pkg;

    localparam int unsigned DIGITS_MAX = 10;
    localparam int unsigned IDX_W = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Reciprocal of ten: q = (x * DIV10_MAGIC) >> DIV10_SHIFT is exact for 32-bit x
    localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

    // One converted number: sign, index of its leading digit, digits ones first
    typedef struct packed {
        logic                                neg;
        logic [IDX_W-1:0]                    top;
        logic [DIGITS_MAX-1:0][DIGIT_W-1:0]  digits;
    } entry_t;

    // Queue write side from the front
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/core/sdta_front.sv
// Front end: accepts a value, takes its magnitude and splits it into decimal digits.
module sdta_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sdta_pkg::VALUE_W-1:0]        s_tdata,    // [31:0] value
    output sdta_pkg::push_t                     push,
    input  logic                                push_ready
);

    localparam int unsigned PROD_W = 2 * sdta_pkg::VALUE_W;

    logic                                              busy_reg, busy_next;
    logic                                              neg_reg;
    logic [sdta_pkg::VALUE_W-1:0]                      work_reg;
    logic [sdta_pkg::IDX_W-1:0]                        step_reg;
    logic [sdta_pkg::DIGITS_MAX-1:0][sdta_pkg::DIGIT_W-1:0] digits_reg, digits_next;

    logic                                  in_neg;
    logic [sdta_pkg::VALUE_W-1:0]          in_mag;
    logic [PROD_W-1:0]                     product;
    logic [sdta_pkg::VALUE_W-1:0]          quot;
    logic [sdta_pkg::VALUE_W-1:0]          quot_x10;
    logic [sdta_pkg::VALUE_W-1:0]          rem_full;
    logic                                  done;

    assign s_tready = !busy_reg;

    // Sign and unsigned magnitude; the most negative value maps onto itself
    assign in_neg = s_tdata[sdta_pkg::VALUE_W-1];
    assign in_mag = in_neg ? (~s_tdata + 1'b1) : s_tdata;

    // Divide by ten through the reciprocal, remainder by shift-add
    assign product  = {{sdta_pkg::VALUE_W{1'b0}}, work_reg} *
                      {{sdta_pkg::VALUE_W{1'b0}}, sdta_pkg::DIV10_MAGIC};
    assign quot     = sdta_pkg::VALUE_W'(product[PROD_W-1:sdta_pkg::DIV10_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = work_reg - quot_x10;
    assign done     = (quot == '0) || (step_reg == sdta_pkg::IDX_W'(sdta_pkg::DIGITS_MAX - 1));

    // Merge the current digit into the digit row
    always_comb begin
        digits_next = digits_reg;
        digits_next[step_reg] = rem_full[sdta_pkg::DIGIT_W-1:0];
    end

    // Hand a finished number to the queue
    always_comb begin
        push.valid        = busy_reg && done;
        push.entry.neg    = neg_reg;
        push.entry.top    = step_reg;
        push.entry.digits = digits_next;
    end

    always_comb begin
        busy_next = busy_reg;
        if (!busy_reg) begin
            busy_next = s_tvalid;
        end else if (done && push_ready) begin
            busy_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Load a new item or advance one digit
    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            neg_reg  <= in_neg;
            work_reg <= in_mag;
            step_reg <= '0;
        end else if (!done) begin
            work_reg   <= quot;
            digits_reg <= digits_next;
            step_reg   <= step_reg + 1'b1;
        end
    end

endmodule

// File: rtl/core/sdta_queue.sv
// Short queue of converted numbers between front and back.
module sdta_queue #(
    parameter int unsigned DEPTH = sdta_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sdta_pkg::push_t         push,
    output logic                    push_ready,
    output logic                    pop_valid,
    output sdta_pkg::entry_t        pop_entry,
    input  logic                    pop,
    output sdta_pkg::queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sdta_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_entry    = mem[rd_ptr_reg];
    assign do_push      = push.valid && push_ready;
    assign do_pop       = pop && pop_valid;

    // Store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/sdta_back.sv
// Back end: walks a converted number and sends its characters one per cycle while the receiver is ready.
module sdta_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    input  sdta_pkg::entry_t              pop_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdta_pkg::CHAR_W-1:0]   m_tdata,    // [7:0] character
    output logic                          m_tlast
);

    logic                                  cur_valid_reg;
    logic                                  neg_pend_reg;
    logic [sdta_pkg::IDX_W-1:0]            idx_reg;
    logic [sdta_pkg::DIGITS_MAX-1:0][sdta_pkg::DIGIT_W-1:0] digits_reg;
    logic                                  m_valid_reg;
    logic [sdta_pkg::CHAR_W-1:0]           m_char_reg;
    logic                                  m_last_reg;

    logic                                  out_free, emit, last_char;
    logic [sdta_pkg::CHAR_W-1:0]           char_next;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_char_reg;
    assign m_tlast   = m_last_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = cur_valid_reg && out_free;
    assign last_char = !neg_pend_reg && (idx_reg == '0);
    assign pop       = pop_valid && (!cur_valid_reg || (emit && last_char));

    // Pick the sign or the current digit
    assign char_next = neg_pend_reg ? sdta_pkg::ASCII_MINUS :
                       sdta_pkg::ASCII_ZERO +
                       {{(sdta_pkg::CHAR_W - sdta_pkg::DIGIT_W){1'b0}}, digits_reg[idx_reg]};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= cur_valid_reg;
            end
            if (pop) begin
                cur_valid_reg <= 1'b1;
            end else if (emit && last_char) begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    // Load the next number or step to the next character
    always_ff @(posedge aclk) begin
        if (pop) begin
            neg_pend_reg <= pop_entry.neg;
            idx_reg      <= pop_entry.top;
            digits_reg   <= pop_entry.digits;
        end else if (emit) begin
            if (neg_pend_reg) begin
                neg_pend_reg <= 1'b0;
            end else if (idx_reg != '0) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_char_reg <= char_next;
            m_last_reg <= last_char;
        end
    end

endmodule

// File: rtl/core/signed_decimal_to_ascii.sv
// Signed 32-bit integer in, its decimal text out as a run of ASCII characters
// (an optional '-' then the digits, most significant first, no leading zeros,
// tlast on the final one). The front splits the magnitude into digits with a
// divide-by-ten multiplier, one digit per cycle. The back sends one character
// per cycle while the receiver is ready, so a number of d digits leaves as d
// characters, or d + 1 when negative. The queue between them lets the front
// work on the next number while the back is still sending or is stalled.
`include "assert_macros.svh"

module signed_decimal_to_ascii #(
    parameter int unsigned QUEUE_DEPTH = sdta_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdta_pkg::VALUE_W-1:0]  s_tdata,    // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdta_pkg::CHAR_W-1:0]   m_tdata,    // [7:0] character
    output logic                          m_tlast
);

    sdta_pkg::push_t         push;
    logic                    push_ready;
    logic                    pop_valid;
    sdta_pkg::entry_t        pop_entry;
    logic                    pop;
    sdta_pkg::queue_status_t q_status;

    sdta_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready)
    );

    sdta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .status     (q_status)
    );

    sdta_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A minus sign never ends a run
    `ASSERT_IMPLY(a_minus_not_last, aclk, aresetn, m_tvalid && (m_tdata == sdta_pkg::ASCII_MINUS), !m_tlast)
    // Every character sent is a sign or a digit
    `ASSERT_IMPLY(a_char_legal, aclk, aresetn, m_tvalid, (m_tdata == sdta_pkg::ASCII_MINUS) || ((m_tdata >= sdta_pkg::ASCII_ZERO) && (m_tdata <= sdta_pkg::ASCII_NINE)))
    // An idle front has nothing to push
    `ASSERT_IMPLY(a_idle_no_push, aclk, aresetn, s_tready, !push.valid)
    // The queue is never full and empty at once, and a pushed number has at most ten digits
    `ASSERT_NEVER(a_queue_count, aclk, aresetn, q_status.full && q_status.empty)
    `ASSERT_IMPLY(a_top_range, aclk, aresetn, push.valid, push.entry.top <= sdta_pkg::IDX_W'(sdta_pkg::DIGITS_MAX - 1))

endmodule

// File: verif/signed_decimal_to_ascii_test.sv
// Self-checking testbench for the signed decimal to ASCII converter.
`timescale 1ns / 1ps

module signed_decimal_to_ascii_test;

    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_OFF_AT = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DIRECTED_N = 20;

    // One expected character of a run
    typedef struct packed {
        logic [sdta_pkg::CHAR_W-1:0] character;
        logic                        last;
    } char_t;

    // One directed row: the number and, where obvious, its text
    typedef struct {
        logic [sdta_pkg::VALUE_W-1:0] value;
        string                        text;
    } row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sdta_pkg::VALUE_W-1:0]  s_tdata;     // [31:0] value
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sdta_pkg::CHAR_W-1:0]   m_tdata;     // [7:0] character
    logic                          m_tlast;

    char_t expected_chars[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    numbers_sent = 0;
    int    negatives_sent = 0;
    int    chars_seen = 0;
    int    burst_left = 0;
    bit    hold_off_req = 1'b0;
    bit    hold_off_seen = 1'b0;
    bit [sdta_pkg::DIGITS_MAX:1] lengths_seen = '0;

    row_t directed_rows [DIRECTED_N] = '{
        '{32'd0,                "0"},
        '{32'd1,                "1"},
        '{-32'sd1,              "-1"},
        '{32'sd2147483647,      "2147483647"},
        '{32'h8000_0000,        "-2147483648"},
        '{32'd9,                ""},
        '{-32'sd9,              ""},
        '{32'd10,               ""},
        '{-32'sd10,             ""},
        '{32'd99,               ""},
        '{32'd100,              ""},
        '{-32'sd12345,          ""},
        '{32'd999999999,        ""},
        '{32'd1000000000,       ""},
        '{-32'sd1000000000,     ""},
        '{-32'sd2147483647,     ""},
        '{32'h5555_5555,        ""},
        '{32'hAAAA_AAAA,        ""},
        '{32'd1234567890,       ""},
        '{-32'sd987654321,      ""}
    };

    signed_decimal_to_ascii uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what);
        $display("[cycle %0d] mismatch: %s", cycle_count, what);
        error_count++;
    endtask

    // Queue the characters of a number's decimal text
    function automatic void predict_chars(input logic [sdta_pkg::VALUE_W-1:0] value);
        logic [sdta_pkg::VALUE_W-1:0] mag;
        logic [sdta_pkg::DIGIT_W-1:0] digit_buf [sdta_pkg::DIGITS_MAX];
        int n;
        mag = value[sdta_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
        n = 0;
        do begin
            digit_buf[n] = sdta_pkg::DIGIT_W'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != 0);
        lengths_seen[n] = 1'b1;
        if (value[sdta_pkg::VALUE_W-1])
            expected_chars.push_back(char_t'{sdta_pkg::ASCII_MINUS, 1'b0});
        for (int k = n - 1; k >= 0; k--)
            expected_chars.push_back(char_t'{sdta_pkg::ASCII_ZERO +
                                             sdta_pkg::CHAR_W'(digit_buf[k]), k == 0});
    endfunction

    // Offer one item in bursts with random gaps; hold valid until taken
    task automatic send_number(input logic [sdta_pkg::VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = hold_off_req ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        numbers_sent++;
        if (value[sdta_pkg::VALUE_W-1]) negatives_sent++;
    endtask

    // Stimulus: directed rows, then random numbers of every length
    initial begin
        logic [sdta_pkg::VALUE_W-1:0] value;
        longint unsigned lo;
        longint unsigned hi;
        int n;
        int pick;
        bit neg;
        string text;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            text = directed_rows[i].text;
            if (text.len() != 0) begin
                for (int k = 0; k < text.len(); k++)
                    expected_chars.push_back(char_t'{text[k], k == text.len() - 1});
            end else begin
                predict_chars(directed_rows[i].value);
            end
            send_number(directed_rows[i].value);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_OFF_AT) hold_off_req = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                value = $urandom();
            end else if (pick < 9) begin
                // pick a digit count, then a magnitude of exactly that length
                n = $urandom_range(1, sdta_pkg::DIGITS_MAX);
                neg = $urandom_range(0, 1);
                lo = 1;
                for (int k = 1; k < n; k++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (n == 1) lo = 0;
                if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
                value = $urandom_range(32'(hi), 32'(lo));
                if (neg) value = ~value + 1'b1;
            end else begin
                // boundary values around powers of ten and the extremes
                n = $urandom_range(0, sdta_pkg::DIGITS_MAX - 1);
                lo = 1;
                for (int k = 0; k < n; k++) lo = lo * 10;
                value = 32'(lo) + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 1)) value = ~value + 1'b1;
                if ($urandom_range(0, 4) == 0)
                    value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            predict_chars(value);
            send_number(value);
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

        $display("Converted %0d numbers (%0d negative) into %0d characters.",
                 numbers_sent, negatives_sent, chars_seen);
        $display("Digit counts covered (bit n = n digits): %b, long receiver hold-off: %0d",
                 lengths_seen, hold_off_seen);
        if (error_count == 0) begin
            $display("** signed_decimal_to_ascii: PASSED **");
        end else begin
            $display("** signed_decimal_to_ascii: FAILED **");
        end
        $finish;
    end

    // Receiver: windows of ready patterns, plus one long hold-off on request
    initial begin
        int mode;
        int step;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        mode = 0;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_off_seen = 1'b1;
            end else begin
                for (step = 0; step < 32; step++) begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= ((step % 5) >= 2);
                    endcase
                    @(posedge aclk);
                end
                mode = $urandom_range(0, 3);
            end
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge aclk) begin
        char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          m_tdata, m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.character)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_tdata, want.character));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                              m_tlast, want.last, want.character));
            end
        end
    end

    // Watchdog: end the run once the cycle limit is reached
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_chars.size());
            $display("** signed_decimal_to_ascii: FAILED **");
            $finish;
        end
    end

endmodule
